>>> sv/exti_pkg.sv
`timescale 1ns / 1ps

package exti_pkg;

  // Item action codes
  localparam logic [1:0] ACT_SAMPLE  = 2'd0;
  localparam logic [1:0] ACT_TRIGGER = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_IRQ_MASK       = 2'd0;
  localparam logic [1:0] REG_RISING_SELECT  = 2'd1;
  localparam logic [1:0] REG_FALLING_SELECT = 2'd2;
  localparam logic [1:0] REG_PORT_SELECT    = 2'd3;

  localparam int unsigned LINE_W = 16;
  localparam int unsigned PIN_W  = 64;
  localparam int unsigned CODE_W = 4;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned ADDR_W = 5;

  typedef struct packed {
    logic [LINE_W-1:0]        irq_mask;
    logic [LINE_W-1:0]        rising_select;
    logic [LINE_W-1:0]        falling_select;
    logic [LINE_W*CODE_W-1:0] port_select;
  } cfg_t;

  typedef struct packed {
    logic       accept;
    logic [1:0] action;
  } lane_ctl_t;

endpackage

>>> sv/exti_item_if.sv
`timescale 1ns / 1ps

interface exti_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] pin_levels;
  logic [15:0] line_bits;

  modport source (output valid, output action, output pin_levels, output line_bits,
                  input ready);
  modport sink (input valid, input action, input pin_levels, input line_bits,
                output ready);
endinterface

>>> sv/exti_result_if.sv
`timescale 1ns / 1ps

interface exti_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] pending_lines;
  logic [15:0] masked_requests;
  logic        vector_line0;
  logic        vector_line1;
  logic        vector_line2;
  logic        vector_line3;
  logic        vector_line4;
  logic        vector_lines_9_5;
  logic        vector_lines_15_10;

  modport source (output valid, output pending_lines, output masked_requests,
                  output vector_line0, output vector_line1, output vector_line2,
                  output vector_line3, output vector_line4, output vector_lines_9_5,
                  output vector_lines_15_10, input ready);
  modport sink (input valid, input pending_lines, input masked_requests,
                input vector_line0, input vector_line1, input vector_line2,
                input vector_line3, input vector_line4, input vector_lines_9_5,
                input vector_lines_15_10, output ready);
endinterface

>>> sv/exti_regs.sv
`timescale 1ns / 1ps

module exti_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [exti_pkg::ADDR_W-1:0] paddr,
  input  logic [exti_pkg::DATA_W-1:0] pwdata,
  output logic [exti_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output exti_pkg::cfg_t              cfg
);
  import exti_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:3];

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_IRQ_MASK:       cfg.irq_mask       <= pwdata[LINE_W-1:0];
        REG_RISING_SELECT:  cfg.rising_select  <= pwdata[LINE_W-1:0];
        REG_FALLING_SELECT: cfg.falling_select <= pwdata[LINE_W-1:0];
        REG_PORT_SELECT:    cfg.port_select    <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_IRQ_MASK:       prdata = {48'd0, cfg.irq_mask};
      REG_RISING_SELECT:  prdata = {48'd0, cfg.rising_select};
      REG_FALLING_SELECT: prdata = {48'd0, cfg.falling_select};
      REG_PORT_SELECT:    prdata = cfg.port_select;
      default:            prdata = '0;
    endcase
  end

endmodule

>>> sv/exti_lane.sv
`timescale 1ns / 1ps

module exti_lane #(
  parameter int LINE      = 0,
  parameter int NUM_PORTS = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  exti_pkg::lane_ctl_t         ctl,
  input  logic [exti_pkg::PIN_W-1:0]  pins,
  input  logic                        line_bit,
  input  logic [exti_pkg::CODE_W-1:0] code,
  input  logic                        rise_en,
  input  logic                        fall_en,
  output logic                        pending_next
);
  import exti_pkg::*;

  localparam logic [3:0]        LINE_ID  = 4'(LINE);
  localparam logic [CODE_W-1:0] PORT_CNT = CODE_W'(NUM_PORTS);

  logic       prev_level;
  logic       pending;
  logic       level;
  logic [5:0] pin_idx;
  logic       edge_hit;

  // Pick this line's pin from the selected port; unknown ports read low
  assign pin_idx  = {code[1:0], LINE_ID};
  assign level    = (code < PORT_CNT) ? pins[pin_idx] : 1'b0;
  assign edge_hit = (level && !prev_level && rise_en) || (!level && prev_level && fall_en);

  // Next pending bit for the accepted action
  always_comb begin
    case (ctl.action)
      ACT_SAMPLE:  pending_next = pending | edge_hit;
      ACT_TRIGGER: pending_next = pending | line_bit;
      ACT_CLEAR:   pending_next = pending & ~line_bit;
      default:     pending_next = pending;
    endcase
  end

  // Advance line state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level <= 1'b0;
      pending    <= 1'b0;
    end else if (ctl.accept) begin
      pending <= pending_next;
      if (ctl.action == ACT_SAMPLE) begin
        prev_level <= level;
      end
    end
  end

endmodule

>>> sv/exti_merge.sv
`timescale 1ns / 1ps

module exti_merge (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [exti_pkg::LINE_W-1:0] pending_next,
  input  logic [exti_pkg::LINE_W-1:0] irq_mask,
  output logic                        hold_full,
  exti_result_if.source               result_out
);
  import exti_pkg::*;

  logic [LINE_W-1:0] masked;

  assign masked    = pending_next & irq_mask;
  assign hold_full = result_out.valid && !result_out.ready;

  // Track the output register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (accept) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  // Load the combined lane results
  always_ff @(posedge clk) begin
    if (accept) begin
      result_out.pending_lines      <= pending_next;
      result_out.masked_requests    <= masked;
      result_out.vector_line0       <= masked[0];
      result_out.vector_line1       <= masked[1];
      result_out.vector_line2       <= masked[2];
      result_out.vector_line3       <= masked[3];
      result_out.vector_line4       <= masked[4];
      result_out.vector_lines_9_5   <= |masked[9:5];
      result_out.vector_lines_15_10 <= |masked[15:10];
    end
  end

endmodule

>>> sv/external_interrupt_line_controller_top.sv
`timescale 1ns / 1ps
// External interrupt line controller, sixteen lines.
// item_in carries one item: action (sample pins, software trigger, clear),
// the 64 pin levels and a line mask. result_out returns one result per item:
// pending bits, masked requests and the grouped vector requests.
// Each line is a lane that picks its pin by its port code, detects edges
// against its kept level and holds its pending bit; a merge stage applies the
// mask, forms the vectors and registers the result.
// A result is registered and shows in the cycle after its item is accepted.
// Throughput is one item per cycle while results drain, set by the single
// output register. item_in.ready drops only while a result waits and
// result_out.ready is low; the stalled result then holds. The user must
// write configuration through the APB port (64-bit data, registers at byte 0,
// 8, 16, 24) only while idle; the block does not enforce this. Synchronous
// reset clears configuration, levels and pending bits, empties the output register.
module external_interrupt_line_controller_top #(
  parameter int NUM_PORTS = 4,
  parameter int NUM_LINES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  exti_item_if.sink                   item_in,
  exti_result_if.source               result_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [exti_pkg::ADDR_W-1:0] paddr,
  input  logic [exti_pkg::DATA_W-1:0] pwdata,
  output logic [exti_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import exti_pkg::*;

  localparam logic [LINE_W-1:0] LINE_MASK = LINE_W'((17'(1) << NUM_LINES) - 17'(1));

  cfg_t              cfg;
  lane_ctl_t         ctl;
  logic              accept;
  logic              hold_full;
  logic [LINE_W-1:0] pending_next;

  exti_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Take an item whenever the output register is free or being drained
  assign item_in.ready = !hold_full;
  assign accept        = item_in.valid && item_in.ready;
  assign ctl.accept    = accept;
  assign ctl.action    = item_in.action;

  // One lane per line; missing lines stay zero
  for (genvar n = 0; n < LINE_W; n++) begin : g_lane
    if (n < NUM_LINES) begin : g_on
      exti_lane #(
        .LINE      (n),
        .NUM_PORTS (NUM_PORTS)
      ) u_lane (
        .clk          (clk),
        .rst          (rst),
        .ctl          (ctl),
        .pins         (item_in.pin_levels),
        .line_bit     (item_in.line_bits[n]),
        .code         (cfg.port_select[CODE_W*n +: CODE_W]),
        .rise_en      (cfg.rising_select[n]),
        .fall_en      (cfg.falling_select[n]),
        .pending_next (pending_next[n])
      );
    end else begin : g_off
      assign pending_next[n] = 1'b0;
    end
  end

  exti_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .pending_next (pending_next),
    .irq_mask     (cfg.irq_mask),
    .hold_full    (hold_full),
    .result_out   (result_out)
  );

  // A clear item leaves its lines not pending
  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && item_in.action == ACT_CLEAR |=>
      (result_out.pending_lines & $past(item_in.line_bits)) == '0)
    else $error("cleared line still pending");

  // A trigger item leaves its existing lines pending
  a_trigger: assert property (@(posedge clk) disable iff (rst)
    accept && item_in.action == ACT_TRIGGER |=>
      (result_out.pending_lines & ($past(item_in.line_bits) & LINE_MASK)) ==
      ($past(item_in.line_bits) & LINE_MASK))
    else $error("triggered line not pending");

  // Masked requests never exceed pending bits
  a_masked: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> (result_out.masked_requests & ~result_out.pending_lines) == '0)
    else $error("masked request without pending bit");

  // Grouped vector follows the masked requests of its lines
  a_vec_hi: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> result_out.vector_lines_15_10 == (|result_out.masked_requests[15:10]))
    else $error("vector for lines 15 to 10 mismatch");

endmodule

>>> test/external_interrupt_line_controller_top_tb.sv
`timescale 1ns / 1ps

module external_interrupt_line_controller_top_tb;
  import exti_pkg::*;

  localparam int NUM_PORTS = 4;
  localparam int NUM_LINES = 16;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int LONG_STALL = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [1:0]  action;
    logic [63:0] pin_levels;
    logic [15:0] line_bits;
  } exti_item_t;

  typedef struct packed {
    logic [15:0] pending_lines;
    logic [15:0] masked_requests;
    logic        vector_line0;
    logic        vector_line1;
    logic        vector_line2;
    logic        vector_line3;
    logic        vector_line4;
    logic        vector_lines_9_5;
    logic        vector_lines_15_10;
  } exti_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  exti_item_if   item_bus ();
  exti_result_if result_bus ();

  external_interrupt_line_controller_top #(
    .NUM_PORTS(NUM_PORTS),
    .NUM_LINES(NUM_LINES)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .item_in   (item_bus),
    .result_out(result_bus),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Shadow copy of the registers and the line state
  cfg_t        cfg_shadow;
  logic [15:0] kept_levels;
  logic [15:0] pending_state;

  exti_item_t   pending_items[$];
  exti_result_t expected_results[$];

  int error_count = 0;
  int send_idle_pct;
  int recv_idle_pct;
  logic stall_go;
  logic stall_active;

  // Advance the line state by one item and return the pending/request view
  function automatic exti_result_t predict_result(input logic [1:0] action,
                                                  input logic [63:0] pins,
                                                  input logic [15:0] bits);
    logic [15:0] now_levels;
    logic [15:0] rise;
    logic [15:0] fall;
    logic [15:0] masked;
    logic [3:0]  code;
    exti_result_t r;
    case (action)
      ACT_SAMPLE: begin
        now_levels = '0;
        for (int n = 0; n < NUM_LINES; n++) begin
          code = cfg_shadow.port_select[4*n +: 4];
          if (int'(code) < NUM_PORTS) now_levels[n] = pins[16*int'(code) + n];
        end
        rise = now_levels & ~kept_levels;
        fall = kept_levels & ~now_levels;
        pending_state |= (rise & cfg_shadow.rising_select) |
                         (fall & cfg_shadow.falling_select);
        kept_levels = now_levels;
      end
      ACT_TRIGGER: pending_state |= bits;
      ACT_CLEAR:   pending_state &= ~bits;
      default: ;
    endcase
    masked = pending_state & cfg_shadow.irq_mask;
    r.pending_lines      = pending_state;
    r.masked_requests    = masked;
    r.vector_line0       = masked[0];
    r.vector_line1       = masked[1];
    r.vector_line2       = masked[2];
    r.vector_line3       = masked[3];
    r.vector_line4       = masked[4];
    r.vector_lines_9_5   = |masked[9:5];
    r.vector_lines_15_10 = |masked[15:10];
    return r;
  endfunction

  function automatic logic [15:0] random_line_word();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Item driver: hold the offered item until taken, then advance or idle
  always @(posedge clk) begin
    if (rst) begin
      item_bus.valid <= 1'b0;
      kept_levels   = '0;
      pending_state = '0;
    end else begin
      if (item_bus.valid && item_bus.ready)
        expected_results.push_back(predict_result(item_bus.action, item_bus.pin_levels,
                                                  item_bus.line_bits));
      if (!item_bus.valid || item_bus.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          exti_item_t it;
          it = pending_items.pop_front();
          item_bus.valid      <= 1'b1;
          item_bus.action     <= it.action;
          item_bus.pin_levels <= it.pin_levels;
          item_bus.line_bits  <= it.line_bits;
        end else begin
          item_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each taken result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      exti_result_t got;
      exti_result_t want;
      got.pending_lines      = result_bus.pending_lines;
      got.masked_requests    = result_bus.masked_requests;
      got.vector_line0       = result_bus.vector_line0;
      got.vector_line1       = result_bus.vector_line1;
      got.vector_line2       = result_bus.vector_line2;
      got.vector_line3       = result_bus.vector_line3;
      got.vector_line4       = result_bus.vector_line4;
      got.vector_lines_9_5   = result_bus.vector_lines_9_5;
      got.vector_lines_15_10 = result_bus.vector_lines_15_10;
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result: pending %h masked %h", got.pending_lines,
                   got.masked_requests);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("mismatch: pending %h/%h masked %h/%h vec %b%b%b%b%b%b%b/%b%b%b%b%b%b%b",
                     want.pending_lines, got.pending_lines,
                     want.masked_requests, got.masked_requests,
                     want.vector_lines_15_10, want.vector_lines_9_5, want.vector_line4,
                     want.vector_line3, want.vector_line2, want.vector_line1,
                     want.vector_line0,
                     got.vector_lines_15_10, got.vector_lines_9_5, got.vector_line4,
                     got.vector_line3, got.vector_line2, got.vector_line1,
                     got.vector_line0);
        end
      end
    end
  end

  // Receiver ready: random idling, forced low during the long stall
  always @(posedge clk) begin
    if (rst || stall_active) result_bus.ready <= 1'b0;
    else result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Long receiver stall, counted here while the sender keeps offering
  initial begin
    stall_active <= 1'b0;
    wait (stall_go);
    @(posedge clk);
    stall_active <= 1'b1;
    repeat (LONG_STALL) @(posedge clk);
    stall_active <= 1'b0;
  end

  task automatic queue_item(input logic [1:0] action, input logic [63:0] pins,
                            input logic [15:0] bits);
    exti_item_t it;
    it.action     = action;
    it.pin_levels = pins;
    it.line_bits  = bits;
    pending_items.push_back(it);
  endtask

  // Wait until every item is taken and every result has come back
  task automatic wait_idle();
    while (pending_items.size() != 0 || item_bus.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [63:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (index)
      REG_IRQ_MASK:       cfg_shadow.irq_mask       = value[15:0];
      REG_RISING_SELECT:  cfg_shadow.rising_select  = value[15:0];
      REG_FALLING_SELECT: cfg_shadow.falling_select = value[15:0];
      default:            cfg_shadow.port_select    = value;
    endcase
  endtask

  task automatic configure(input logic [15:0] mask, input logic [15:0] rising,
                           input logic [15:0] falling, input logic [63:0] ports);
    wait_idle();
    write_register(REG_IRQ_MASK, {48'h0, mask});
    write_register(REG_RISING_SELECT, {48'h0, rising});
    write_register(REG_FALLING_SELECT, {48'h0, falling});
    write_register(REG_PORT_SELECT, ports);
    @(negedge clk);
  endtask

  // Run limit
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    logic [63:0] last_pins;
    logic [63:0] pins;
    logic [63:0] ports;
    logic [15:0] bits;
    logic [1:0]  action;
    int pick;
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    stall_go      = 1'b0;
    send_idle_pct = 25;
    recv_idle_pct = 67;
    cfg_shadow    = '0;
    last_pins     = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Rising edges only, every line on port 0, all lines enabled
    configure(16'hFFFF, 16'hFFFF, 16'h0000, 64'h0);
    queue_item(ACT_SAMPLE, {64{1'b1}}, 16'h0000);
    queue_item(ACT_SAMPLE, 64'h0, 16'hFFFF);
    queue_item(ACT_CLEAR, {64{1'b1}}, 16'hFFFF);
    queue_item(ACT_SAMPLE, 64'h0000_0000_0000_FFFF, 16'h0000);
    queue_item(ACT_TRIGGER, 64'h0, 16'h0000);
    queue_item(ACT_CLEAR, 64'h0, 16'h00FF);
    queue_item(ACT_UNUSED, {64{1'b1}}, 16'hFFFF);

    // Falling edges only, everything masked off
    configure(16'h0000, 16'h0000, 16'hFFFF, 64'h0);
    queue_item(ACT_SAMPLE, 64'h0, 16'h0000);
    queue_item(ACT_SAMPLE, {64{1'b1}}, 16'h0000);
    queue_item(ACT_CLEAR, 64'h0, 16'hA5A5);
    queue_item(ACT_TRIGGER, 64'h0, 16'h8001);

    // Both edges, every port code out of range so all lines read low
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, {64{1'b1}});
    queue_item(ACT_CLEAR, 64'h0, 16'hFFFF);
    queue_item(ACT_SAMPLE, {64{1'b1}}, 16'h0000);
    queue_item(ACT_SAMPLE, {64{1'b1}}, 16'h0000);
    queue_item(ACT_TRIGGER, {64{1'b1}}, 16'h0421);
    queue_item(ACT_CLEAR, 64'h0, 16'h0021);

    // Lines spread over all four ports, mixed edges and vector groups
    configure(16'h83E1, 16'h00FF, 16'hFF00, 64'h3210_3210_3210_3210);
    queue_item(ACT_SAMPLE, 64'hFFFF_0000_0000_0000, 16'h0000);
    queue_item(ACT_SAMPLE, 64'h0000_FFFF_0000_0000, 16'h0000);
    queue_item(ACT_SAMPLE, 64'h0000_0000_FFFF_0000, 16'h0000);
    queue_item(ACT_SAMPLE, 64'h0000_0000_0000_FFFF, 16'h0000);
    queue_item(ACT_SAMPLE, 64'h0, 16'h0000);
    queue_item(ACT_TRIGGER, 64'h0, 16'h0400);
    queue_item(ACT_TRIGGER, 64'h0, 16'h0020);

    // Random phases with fresh settings each time
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      if (p < 3) begin
        send_idle_pct <= 25;
        recv_idle_pct <= 67;
      end else if (p < 6) begin
        send_idle_pct <= 67;
        recv_idle_pct <= 25;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      // Mostly in-range port codes, now and then all of one extreme
      pick = $urandom_range(7);
      for (int n = 0; n < NUM_LINES; n++)
        ports[4*n +: 4] = ($urandom_range(4) == 0) ? 4'($urandom_range(15))
                                                   : 4'($urandom_range(NUM_PORTS - 1));
      if (pick == 0) ports = '0;
      else if (pick == 1) ports = {64{1'b1}};
      configure(random_line_word(), random_line_word(), random_line_word(), ports);

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick = $urandom_range(99);
        if (pick < 55) action = ACT_SAMPLE;
        else if (pick < 72) action = ACT_TRIGGER;
        else if (pick < 95) action = ACT_CLEAR;
        else action = ACT_UNUSED;
        // Sparse toggles of the last pins give isolated edges
        case ($urandom_range(9))
          0: pins = '0;
          1: pins = {64{1'b1}};
          2, 3, 4, 5:
            pins = last_pins ^ ({$urandom, $urandom} & {$urandom, $urandom} &
                                {$urandom, $urandom});
          default: pins = {$urandom, $urandom};
        endcase
        if (action == ACT_SAMPLE) last_pins = pins;
        pick = $urandom_range(9);
        if (pick == 0) bits = 16'hFFFF;
        else if (pick == 1) bits = 16'h0000;
        else bits = 16'($urandom);
        queue_item(action, pins, bits);
      end
      if (p == RANDOM_PHASES - 1) stall_go <= 1'b1;
    end

    wait_idle();
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
